// ===== rtl/rttb_pkg.sv =====
// Shared types and constants for the rate tick timer bank.
// Used by rttb_ctrl, rttb_dp and rate_tick_timer_bank; depends on nothing else.
`default_nettype none

package rttb_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int RATE_LIMIT     = 100;
    localparam int RATE_NUMER     = 2000;

    localparam int REQ_W      = 3;
    localparam int IDX_W      = 4;
    localparam int TIME_W     = 32;
    localparam int RATE_W     = 10;
    localparam int PEND_W     = 16;
    localparam int INTERVAL_W = 10;
    localparam int DIVISOR_W  = RATE_W + 1;
    localparam int IDX_EXT_W  = 9;

    localparam logic [PEND_W-1:0] PENDING_MAX = {PEND_W{1'b1}};

    typedef enum logic [REQ_W-1:0] {
        REQ_SET_RATE  = 3'd0,
        REQ_POLL      = 3'd1,
        REQ_ACK       = 3'd2,
        REQ_CONT_ON   = 3'd3,
        REQ_CONT_OFF  = 3'd4,
        REQ_GET_EVENT = 3'd5
    } t_req;

    typedef struct packed {
        logic                  ticking;
        logic [INTERVAL_W-1:0] interval;
        logic [TIME_W-1:0]     start;
        logic [TIME_W-1:0]     issued;
        logic [PEND_W-1:0]     pending;
        logic                  cont;
    } t_rec;

    typedef struct packed {
        logic capture;
        logic load_rec;
        logic div_start;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rttb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module rttb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                         i_wr_data,
    input  wire logic                                     i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/rttb_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Standalone; used by rttb_dp for the interval and the ticks owed.
`default_nettype none

module rttb_div #(
    parameter int NW = 32,
    parameter int DW = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic      [NW-1:0] o_quo,
    output logic               o_busy,
    output logic               o_done
);

    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] r_rem, n_rem;
    logic [NW-1:0] r_quo, n_quo;
    logic [DW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    always_comb begin
        trial = {r_rem, r_quo[NW-1]};
        ge    = (trial >= {1'b0, r_dvs});
        diff  = trial - {1'b0, r_dvs};
        // remainder stays below the divisor, so DW bits hold it
        n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
        n_quo = {r_quo[NW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo  = r_quo;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== rtl/rttb_ctrl.sv =====
// Request sequencer: read the timer record, run the divider when needed,
// then write back and post the result word. Depends on rttb_pkg.
`default_nettype none

module rttb_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire rttb_pkg::t_sts  i_sts,
    output rttb_pkg::t_cmd       o_cmd
);

    import rttb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_WRITE
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                cmd.load_rec = 1'b1;
                if (i_sts.need_div) begin
                    cmd.div_start = 1'b1;
                    n_state       = S_DIV;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                // hold until the output register can take the word
                if (i_sts.out_free) begin
                    cmd.commit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = cmd;

endmodule

`default_nettype wire

// ===== rtl/rttb_dp.sv =====
// Datapath: request registers, timer record store, shared divider, update
// logic and output register. Depends on rttb_pkg, rttb_ram and rttb_div.
`default_nettype none

module rttb_dp #(
    parameter int NUM_TIMERS = rttb_pkg::NUM_TIMERS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rttb_pkg::t_cmd                i_cmd,
    output rttb_pkg::t_sts                     o_sts,
    input  wire logic [rttb_pkg::REQ_W-1:0]    i_req_type,
    input  wire logic [rttb_pkg::IDX_W-1:0]    i_timer_index,
    input  wire logic [rttb_pkg::TIME_W-1:0]   i_now_ms,
    input  wire logic [rttb_pkg::RATE_W-1:0]   i_rate_value,
    input  wire logic [rttb_pkg::PEND_W-1:0]   i_ack_count,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_status,
    output logic                               o_tick_fired,
    output logic [rttb_pkg::PEND_W-1:0]        o_pending_count,
    output logic                               o_event_kind
);

    import rttb_pkg::*;

    localparam int AW    = addr_w(NUM_TIMERS);
    localparam int REC_W = $bits(t_rec);

    // request registers
    logic [REQ_W-1:0]    r_req;
    logic [AW-1:0]       r_idx;
    logic                r_in_range;
    logic [TIME_W-1:0]   r_now;
    logic [RATE_W-1:0]   r_rate;
    logic [PEND_W-1:0]   r_ack;
    logic                r_rd_vld;
    t_rec                r_rec;

    logic [NUM_TIMERS-1:0] r_vld;

    logic [IDX_EXT_W-1:0] idx_ext;
    logic                 idx_ok;
    logic [REC_W-1:0]     ram_rd;
    t_rec                 cur;
    logic                 ram_we;

    logic [TIME_W-1:0]    div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic [TIME_W-1:0]    quo;
    logic                 div_busy;
    logic                 div_done;

    t_rec                 n_rec;
    logic                 n_status;
    logic                 n_fired;
    logic                 n_event;
    logic [TIME_W-1:0]    n_issued;
    logic [PEND_W-1:0]    avail;
    logic [PEND_W-1:0]    take;
    logic                 rate_ok;

    logic                 r_out_valid;
    logic                 r_status;
    logic                 r_fired;
    logic [PEND_W-1:0]    r_pend;
    logic                 r_event;

    assign idx_ext = {{(IDX_EXT_W-IDX_W){1'b0}}, i_timer_index};
    assign idx_ok  = (idx_ext < IDX_EXT_W'(NUM_TIMERS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req      <= i_req_type;
            r_idx      <= idx_ext[AW-1:0];
            r_in_range <= idx_ok;
            r_now      <= i_now_ms;
            r_rate     <= i_rate_value;
            r_ack      <= i_ack_count;
            r_rd_vld   <= idx_ok && r_vld[idx_ext[AW-1:0]];
        end
        if (i_cmd.load_rec) begin
            r_rec <= cur;
        end
    end

    // entries never written read as the reset record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ram_we) begin
            r_vld[r_idx] <= 1'b1;
        end
    end

    rttb_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_TIMERS)
    ) u_rec_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_idx),
        .i_wr_data (n_rec),
        .i_rd_en   (i_cmd.capture),
        .i_rd_addr (idx_ext[AW-1:0]),
        .o_rd_data (ram_rd)
    );

    assign cur     = r_rd_vld ? t_rec'(ram_rd) : '0;
    assign rate_ok = (r_rate <= RATE_W'(RATE_LIMIT));

    // divider operands: interval numerator for set rate, elapsed time for poll
    always_comb begin
        if (r_req == REQ_SET_RATE) begin
            div_dividend = TIME_W'(RATE_NUMER) + TIME_W'(r_rate);
            div_divisor  = {r_rate, 1'b0};
        end else begin
            div_dividend = r_now - cur.start;
            div_divisor  = {1'b0, cur.interval};
        end
    end

    rttb_div #(
        .NW (TIME_W),
        .DW (DIVISOR_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quo      (quo),
        .o_busy     (div_busy),
        .o_done     (div_done)
    );

    always_comb begin
        n_rec    = r_rec;
        n_status = 1'b0;
        n_fired  = 1'b0;
        n_event  = 1'b0;
        n_issued = r_rec.issued + TIME_W'(1);
        avail    = r_rec.pending - PEND_W'(r_rec.cont && (r_rec.pending != '0));
        take     = (r_ack > avail) ? avail : r_ack;
        case (r_req)
            REQ_SET_RATE: begin
                if (!rate_ok) begin
                    n_status = 1'b1;
                end else if (r_rate != '0) begin
                    n_rec.interval = quo[INTERVAL_W-1:0];
                    n_rec.start    = r_now;
                    n_rec.ticking  = 1'b1;
                    n_rec.issued   = '0;
                end else begin
                    n_rec.interval = '0;
                    n_rec.start    = '0;
                    n_rec.ticking  = 1'b0;
                    n_rec.issued   = '0;
                end
            end
            REQ_POLL: begin
                if (r_rec.ticking && (r_rec.interval != '0) && (r_rec.issued < quo)) begin
                    n_rec.issued = n_issued;
                    // restart the time base when the tick count wraps
                    if (n_issued == '0) begin
                        n_rec.start = r_now;
                    end
                    if (r_rec.pending != PENDING_MAX) begin
                        n_rec.pending = r_rec.pending + PEND_W'(1);
                    end
                    n_fired = 1'b1;
                end
            end
            REQ_ACK: begin
                if (r_ack != '0) begin
                    n_rec.pending = r_rec.pending - take;
                end
            end
            REQ_CONT_ON: begin
                if (!r_rec.cont) begin
                    n_rec.cont = 1'b1;
                    if (r_rec.pending != PENDING_MAX) begin
                        n_rec.pending = r_rec.pending + PEND_W'(1);
                    end
                end
            end
            REQ_CONT_OFF: begin
                if (r_rec.cont) begin
                    n_rec.cont = 1'b0;
                    if (r_rec.pending != '0) begin
                        n_rec.pending = r_rec.pending - PEND_W'(1);
                    end
                end
            end
            REQ_GET_EVENT: begin
                n_event = r_rec.cont && (r_rec.pending == PEND_W'(1));
            end
            default: begin
            end
        endcase
    end

    assign ram_we = i_cmd.commit && r_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // drop every field for an index beyond the bank
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= r_in_range && n_status;
            r_fired  <= r_in_range && n_fired;
            r_pend   <= r_in_range ? n_rec.pending : '0;
            r_event  <= r_in_range && n_event;
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.need_div = r_in_range &&
                         (((r_req == REQ_SET_RATE) && (r_rate != '0) && rate_ok) ||
                          ((r_req == REQ_POLL) && cur.ticking && (cur.interval != '0)));
        o_sts.div_done = div_done;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_tick_fired    = r_fired;
    assign o_pending_count = r_pend;
    assign o_event_kind    = r_event;

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_poll_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_req == REQ_POLL)) |-> (n_rec.pending >= r_rec.pending))
        else $error("poll reduced pending ticks");

    a_ack_keeps_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_req == REQ_ACK) && r_rec.cont && (r_rec.pending != '0))
        |-> (n_rec.pending != '0))
        else $error("ack removed the continuous tick");

    a_out_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.commit))
        else $error("result word posted without a commit");

endmodule

`default_nettype wire

// ===== rtl/rate_tick_timer_bank.sv =====
// Bank of tick timers, one request word in and one result word out.
// Set rate (nonzero, in range) and poll of a running timer pass through the
// 32-step shared divider before the result word; other requests skip it. One
// request is handled at a time: input ready rises as the result word is posted,
// and a stalled output holds the bank until the last word is taken.
// Synchronous active-low reset idles all timers and empties the output.
`default_nettype none

module rate_tick_timer_bank #(
    parameter int NUM_TIMERS = rttb_pkg::NUM_TIMERS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [rttb_pkg::REQ_W-1:0]    i_req_type,
    input  wire logic [rttb_pkg::IDX_W-1:0]    i_timer_index,
    input  wire logic [rttb_pkg::TIME_W-1:0]   i_now_ms,
    input  wire logic [rttb_pkg::RATE_W-1:0]   i_rate_value,
    input  wire logic [rttb_pkg::PEND_W-1:0]   i_ack_count,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_status,
    output logic                               o_tick_fired,
    output logic [rttb_pkg::PEND_W-1:0]        o_pending_count,
    output logic                               o_event_kind
);

    import rttb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rttb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rttb_dp #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_req_type      (i_req_type),
        .i_timer_index   (i_timer_index),
        .i_now_ms        (i_now_ms),
        .i_rate_value    (i_rate_value),
        .i_ack_count     (i_ack_count),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_tick_fired    (o_tick_fired),
        .o_pending_count (o_pending_count),
        .o_event_kind    (o_event_kind)
    );

endmodule

`default_nettype wire
